// ----- src/tqm_pkg.sv -----
// tqm_pkg: shared types, widths and constants for the triangle quality metrics block
// used by tqm_root, tqm_angle and triangle_quality_metrics_top; no dependencies
package tqm_pkg;

    localparam int COORD_W  = 16;
    localparam int EDGE_W   = 17;
    localparam int PROD_W   = 34;
    localparam int L2_W     = 34;
    localparam int DOT_W    = 35;
    localparam int CROSS_W  = 34;
    localparam int MAG_W    = 33;
    localparam int HALF_W   = 16;
    localparam int NSQ_W    = 66;
    localparam int SUM_W    = 68;
    localparam int ROOT_W   = 34;
    localparam int LROOT_W  = 17;
    localparam int ANGLE_W  = 16;
    localparam int AREA_W   = 33;
    localparam int IDX_W    = 2;

    localparam int NORM_W   = 41;
    localparam int NORM_STAGES = 3;
    localparam int CORD_W   = 44;
    localparam int Z_W      = 20;
    localparam int CORDIC_STEPS = 17;

    localparam int HALF_PI_Q16 = 102944;
    localparam int PI_Q16      = 205887;
    localparam int ANGLE_MAX   = 51472;

    localparam int FRONT_STAGES = 7;
    localparam int SQRT_STAGES  = ROOT_W;
    localparam int LANE_STAGES  = 1 + NORM_STAGES + CORDIC_STEPS + 1;
    localparam int TOTAL_STAGES = FRONT_STAGES + SQRT_STAGES + LANE_STAGES + 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
    } t_in;

    typedef struct packed {
        logic [ANGLE_W-1:0] largest_angle;
        logic [IDX_W-1:0]   largest_index;
        logic [ANGLE_W-1:0] smallest_angle;
        logic [IDX_W-1:0]   smallest_index;
        logic [AREA_W-1:0]  area;
        logic [LROOT_W-1:0] longest_edge;
        logic               degenerate;
    } t_out;

    // atan(2^-i) in units of 2^-16 rad
    function automatic logic signed [Z_W-1:0] atan_q16(input int unsigned i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:  v = 20'sd51472;
            1:  v = 20'sd30386;
            2:  v = 20'sd16055;
            3:  v = 20'sd8150;
            4:  v = 20'sd4091;
            5:  v = 20'sd2047;
            6:  v = 20'sd1024;
            7:  v = 20'sd512;
            8:  v = 20'sd256;
            9:  v = 20'sd128;
            10: v = 20'sd64;
            11: v = 20'sd32;
            12: v = 20'sd16;
            13: v = 20'sd8;
            14: v = 20'sd4;
            15: v = 20'sd2;
            16: v = 20'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/tqm_root.sv -----
// tqm_root: pipelined bit-per-stage integer square roots of the squared normal
// and of the longest squared edge; depends on tqm_pkg
module tqm_root (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [tqm_pkg::SUM_W-1:0]    i_s,
    input  logic [tqm_pkg::L2_W-1:0]     i_l,
    output logic [tqm_pkg::ROOT_W-1:0]   o_root,
    output logic [tqm_pkg::LROOT_W-1:0]  o_lroot
);
    import tqm_pkg::*;

    logic [SUM_W-1:0]   r_rem   [SQRT_STAGES-1];
    logic [ROOT_W-1:0]  r_root  [SQRT_STAGES];
    logic [L2_W-1:0]    r_lrem  [SQRT_STAGES-1];
    logic [LROOT_W-1:0] r_lroot [SQRT_STAGES];

    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
        localparam int K = SQRT_STAGES - 1 - j;
        logic [SUM_W-1:0]   rem_in;
        logic [ROOT_W-1:0]  root_in;
        logic [L2_W-1:0]    lrem_in;
        logic [LROOT_W-1:0] lroot_in;
        logic [SUM_W+1:0]   d;
        logic               take;

        if (j == 0) begin : g_first
            assign rem_in   = i_s;
            assign root_in  = '0;
            assign lrem_in  = i_l;
            assign lroot_in = '0;
        end else begin : g_next
            assign rem_in   = r_rem[j-1];
            assign root_in  = r_root[j-1];
            assign lrem_in  = r_lrem[j-1];
            assign lroot_in = r_lroot[j-1];
        end

        assign d    = ((SUM_W+2)'(root_in) << (K + 1)) + ((SUM_W+2)'(1) << (2 * K));
        assign take = (SUM_W+2)'(rem_in) >= d;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[j] <= take ? (root_in | (ROOT_W'(1) << K)) : root_in;
            end
        end

        if (j < SQRT_STAGES - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= take ? SUM_W'((SUM_W+2)'(rem_in) - d) : rem_in;
                end
            end
        end

        if (K < LROOT_W) begin : g_lstep
            logic [L2_W+1:0] ld;
            logic            ltake;
            assign ld    = ((L2_W+2)'(lroot_in) << (K + 1)) + ((L2_W+2)'(1) << (2 * K));
            assign ltake = (L2_W+2)'(lrem_in) >= ld;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_lroot[j] <= ltake ? (lroot_in | (LROOT_W'(1) << K)) : lroot_in;
                end
            end
            if (j < SQRT_STAGES - 1) begin : g_lrem
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_lrem[j] <= ltake ? L2_W'((L2_W+2)'(lrem_in) - ld) : lrem_in;
                    end
                end
            end
        end else begin : g_lpass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_lroot[j] <= lroot_in;
                    r_lrem[j]  <= lrem_in;
                end
            end
        end
    end

    assign o_root  = r_root[SQRT_STAGES-1];
    assign o_lroot = r_lroot[SQRT_STAGES-1];

endmodule

// ----- src/tqm_angle.sv -----
// tqm_angle: one angle lane, quadrant fold, pipelined normalize and a
// seventeen-stage vectoring cordic, rounded to q2.14; depends on tqm_pkg
module tqm_angle (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [tqm_pkg::DOT_W:0] i_x,
    input  logic [tqm_pkg::ROOT_W-1:0]    i_y,
    output logic [tqm_pkg::ANGLE_W-1:0]   o_angle
);
    import tqm_pkg::*;

    logic [NORM_W-1:0]        r_a_x, r_a_y;
    logic                     r_a_rot, r_a_zero;
    logic [NORM_W-1:0]        r_n_x [NORM_STAGES];
    logic [NORM_W-1:0]        r_n_y [NORM_STAGES];
    logic                     r_n_rot  [NORM_STAGES];
    logic                     r_n_zero [NORM_STAGES];
    logic signed [CORD_W-1:0] r_c_x [CORDIC_STEPS-1];
    logic signed [CORD_W-1:0] r_c_y [CORDIC_STEPS-1];
    logic                     r_c_zero [CORDIC_STEPS-1];
    logic signed [Z_W-1:0]    r_c_z   [CORDIC_STEPS];
    logic                     r_c_rot [CORDIC_STEPS];
    logic [ANGLE_W-1:0]       r_f_angle;

    // fold a negative x into the first quadrant
    logic xneg;
    assign xneg = i_x < 0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_x    <= xneg ? NORM_W'(i_y) : NORM_W'($unsigned(i_x));
            r_a_y    <= xneg ? NORM_W'($unsigned(-i_x)) : NORM_W'(i_y);
            r_a_rot  <= xneg;
            r_a_zero <= (i_x == '0) && (i_y == '0);
        end
    end

    for (genvar n = 0; n < NORM_STAGES; n++) begin : g_norm
        localparam int SA = 1 << (5 - 2 * n);
        localparam int SB = 1 << (4 - 2 * n);
        logic [NORM_W-1:0] x0, y0, x1, y1, x2, y2;
        logic              rot_in, zero_in;

        if (n == 0) begin : g_first
            assign x0      = r_a_x;
            assign y0      = r_a_y;
            assign rot_in  = r_a_rot;
            assign zero_in = r_a_zero;
        end else begin : g_next
            assign x0      = r_n_x[n-1];
            assign y0      = r_n_y[n-1];
            assign rot_in  = r_n_rot[n-1];
            assign zero_in = r_n_zero[n-1];
        end

        always_comb begin
            x1 = x0;
            y1 = y0;
            if ((x0 >> (NORM_W - SA)) == '0 && (y0 >> (NORM_W - SA)) == '0) begin
                x1 = x0 << SA;
                y1 = y0 << SA;
            end
            x2 = x1;
            y2 = y1;
            if ((x1 >> (NORM_W - SB)) == '0 && (y1 >> (NORM_W - SB)) == '0) begin
                x2 = x1 << SB;
                y2 = y1 << SB;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n_x[n]    <= x2;
                r_n_y[n]    <= y2;
                r_n_rot[n]  <= rot_in;
                r_n_zero[n] <= zero_in;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [CORD_W-1:0] x_in, y_in, x_out, y_out;
        logic signed [Z_W-1:0]    z_in, z_out;
        logic                     rot_in, zero_in;

        if (i == 0) begin : g_first
            assign x_in    = CORD_W'(r_n_x[NORM_STAGES-1]);
            assign y_in    = CORD_W'(r_n_y[NORM_STAGES-1]);
            assign z_in    = '0;
            assign rot_in  = r_n_rot[NORM_STAGES-1];
            assign zero_in = r_n_zero[NORM_STAGES-1];
        end else begin : g_next
            assign x_in    = r_c_x[i-1];
            assign y_in    = r_c_y[i-1];
            assign z_in    = r_c_z[i-1];
            assign rot_in  = r_c_rot[i-1];
            assign zero_in = r_c_zero[i-1];
        end

        always_comb begin
            x_out = x_in;
            y_out = y_in;
            z_out = z_in;
            if (!zero_in) begin
                if (y_in >= 0) begin
                    x_out = x_in + (y_in >>> i);
                    y_out = y_in - (x_in >>> i);
                    z_out = z_in + atan_q16(i);
                end else begin
                    x_out = x_in - (y_in >>> i);
                    y_out = y_in + (x_in >>> i);
                    z_out = z_in - atan_q16(i);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_c_z[i]   <= z_out;
                r_c_rot[i] <= rot_in;
            end
        end

        if (i < CORDIC_STEPS - 1) begin : g_xy
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_c_x[i]    <= x_out;
                    r_c_y[i]    <= y_out;
                    r_c_zero[i] <= zero_in;
                end
            end
        end
    end

    // add the fold offset, clamp to [0, pi] and round to q2.14
    logic signed [Z_W-1:0] zf, zc;
    logic [Z_W-1:0]        zr;

    always_comb begin
        zf = r_c_z[CORDIC_STEPS-1]
           + (r_c_rot[CORDIC_STEPS-1] ? Z_W'(HALF_PI_Q16) : Z_W'(0));
        zc = zf;
        if (zf < 0) begin
            zc = '0;
        end else if (zf > Z_W'(PI_Q16)) begin
            zc = Z_W'(PI_Q16);
        end
        zr = ($unsigned(zc) + Z_W'(2)) >> 2;
        if (zr > Z_W'(ANGLE_MAX)) begin
            zr = Z_W'(ANGLE_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_angle <= zr[ANGLE_W-1:0];
        end
    end

    assign o_angle = r_f_angle;

endmodule

// ----- src/triangle_quality_metrics_top.sv -----
// triangle_quality_metrics_top: angles, area and longest edge of one triangle per item
// depends on tqm_pkg, tqm_root and tqm_angle
//
//   channel  direction  signals                      payload
//   input    in         i_valid / o_ready / i_data   tqm_pkg::t_in
//   output   out        o_valid / i_ready / o_data   tqm_pkg::t_out
//
// one item per cycle while the output is not held; from accept to result: 7 arithmetic stages, 34 root
// stages (one result bit each), 22 angle lane stages (fold, 3 normalize, 17 cordic,
// round), one select and output stage
// synchronous active-low reset clears the valid bits only
// a held result freezes the whole pipeline; nothing is dropped or repeated
module triangle_quality_metrics_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tqm_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output tqm_pkg::t_out  o_data
);
    import tqm_pkg::*;

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    logic [TOTAL_STAGES-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOTAL_STAGES-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[TOTAL_STAGES-1];

    logic signed [COORD_W-1:0] v [3][3];

    always_comb begin
        v[0][0] = i_data.ax; v[0][1] = i_data.ay; v[0][2] = i_data.az;
        v[1][0] = i_data.bx; v[1][1] = i_data.by; v[1][2] = i_data.bz;
        v[2][0] = i_data.cx; v[2][1] = i_data.cy; v[2][2] = i_data.cz;
    end

    // edges
    logic signed [EDGE_W-1:0] r1_e [3][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r1_e[k][i] <= EDGE_W'(v[(k < 2) ? k + 1 : 0][i]) - EDGE_W'(v[k][i]);
                end
            end
        end
    end

    // products
    logic signed [PROD_W-1:0] r2_sq [3][3];
    logic signed [PROD_W-1:0] r2_dp [3][3];
    logic signed [PROD_W-1:0] r2_c  [6];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r2_sq[k][i] <= PROD_W'(r1_e[k][i]) * PROD_W'(r1_e[k][i]);
                    r2_dp[k][i] <= PROD_W'(r1_e[k][i]) * PROD_W'(r1_e[(k > 0) ? k - 1 : 2][i]);
                end
            end
            r2_c[0] <= PROD_W'(r1_e[0][1]) * PROD_W'(r1_e[1][2]);
            r2_c[1] <= PROD_W'(r1_e[0][2]) * PROD_W'(r1_e[1][1]);
            r2_c[2] <= PROD_W'(r1_e[0][2]) * PROD_W'(r1_e[1][0]);
            r2_c[3] <= PROD_W'(r1_e[0][0]) * PROD_W'(r1_e[1][2]);
            r2_c[4] <= PROD_W'(r1_e[0][0]) * PROD_W'(r1_e[1][1]);
            r2_c[5] <= PROD_W'(r1_e[0][1]) * PROD_W'(r1_e[1][0]);
        end
    end

    // squared lengths, dot products, normal
    logic [L2_W-1:0]           r3_l2  [3];
    logic signed [DOT_W-1:0]   r3_dot [3];
    logic signed [CROSS_W-1:0] r3_n   [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r3_l2[k]  <= $unsigned(r2_sq[k][0] + r2_sq[k][1] + r2_sq[k][2]);
                r3_dot[k] <= DOT_W'(r2_dp[k][0]) + DOT_W'(r2_dp[k][1]) + DOT_W'(r2_dp[k][2]);
            end
            r3_n[0] <= CROSS_W'(r2_c[0] - r2_c[1]);
            r3_n[1] <= CROSS_W'(r2_c[2] - r2_c[3]);
            r3_n[2] <= CROSS_W'(r2_c[4] - r2_c[5]);
        end
    end

    // magnitudes, longest squared edge, degenerate flag
    logic [MAG_W-1:0]        r4_mag [3];
    logic [L2_W-1:0]         r4_lmax;
    logic                    r4_degen;
    logic signed [DOT_W-1:0] r4_dot [3];
    logic [L2_W-1:0]         lmax01;

    assign lmax01 = (r3_l2[1] > r3_l2[0]) ? r3_l2[1] : r3_l2[0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r4_mag[k] <= MAG_W'((r3_n[k] < 0) ? $unsigned(-r3_n[k]) : $unsigned(r3_n[k]));
                r4_dot[k] <= r3_dot[k];
            end
            r4_lmax  <= (r3_l2[2] > lmax01) ? r3_l2[2] : lmax01;
            r4_degen <= (r3_l2[0] == '0) || (r3_l2[1] == '0) || (r3_l2[2] == '0);
        end
    end

    // partial products of the squared normal components
    logic [2*(MAG_W-HALF_W)-1:0]   r5_hh [3];
    logic [MAG_W-1:0]              r5_hl [3];
    logic [2*HALF_W-1:0]           r5_ll [3];
    logic [L2_W-1:0]               r5_lmax;
    logic                          r5_degen;
    logic signed [DOT_W-1:0]       r5_dot [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r5_hh[k]  <= (2*(MAG_W-HALF_W))'(r4_mag[k][MAG_W-1:HALF_W])
                           * (2*(MAG_W-HALF_W))'(r4_mag[k][MAG_W-1:HALF_W]);
                r5_hl[k]  <= MAG_W'(r4_mag[k][MAG_W-1:HALF_W]) * MAG_W'(r4_mag[k][HALF_W-1:0]);
                r5_ll[k]  <= (2*HALF_W)'(r4_mag[k][HALF_W-1:0])
                           * (2*HALF_W)'(r4_mag[k][HALF_W-1:0]);
                r5_dot[k] <= r4_dot[k];
            end
            r5_lmax  <= r4_lmax;
            r5_degen <= r4_degen;
        end
    end

    logic [NSQ_W-1:0]        r6_sq [3];
    logic [L2_W-1:0]         r6_lmax;
    logic                    r6_degen;
    logic signed [DOT_W-1:0] r6_dot [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r6_sq[k]  <= (NSQ_W'(r5_hh[k]) << (2 * HALF_W))
                           + (NSQ_W'(r5_hl[k]) << (HALF_W + 1))
                           + NSQ_W'(r5_ll[k]);
                r6_dot[k] <= r5_dot[k];
            end
            r6_lmax  <= r5_lmax;
            r6_degen <= r5_degen;
        end
    end

    logic [SUM_W-1:0]        r7_s;
    logic [L2_W-1:0]         r7_lmax;
    logic                    r7_degen;
    logic signed [DOT_W-1:0] r7_dot [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_s     <= SUM_W'(r6_sq[0]) + SUM_W'(r6_sq[1]) + SUM_W'(r6_sq[2]);
            r7_lmax  <= r6_lmax;
            r7_degen <= r6_degen;
            for (int k = 0; k < 3; k++) begin
                r7_dot[k] <= r6_dot[k];
            end
        end
    end

    logic [ROOT_W-1:0]  root;
    logic [LROOT_W-1:0] lroot;

    tqm_root u_root (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_s     (r7_s),
        .i_l     (r7_lmax),
        .o_root  (root),
        .o_lroot (lroot)
    );

    // side data alongside the root stages
    logic signed [DOT_W-1:0] r_d1_dot   [SQRT_STAGES][3];
    logic                    r_d1_degen [SQRT_STAGES];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_d1_dot[0][k] <= r7_dot[k];
            end
            r_d1_degen[0] <= r7_degen;
            for (int j = 1; j < SQRT_STAGES; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r_d1_dot[j][k] <= r_d1_dot[j-1][k];
                end
                r_d1_degen[j] <= r_d1_degen[j-1];
            end
        end
    end

    logic [ANGLE_W-1:0] ang [3];

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic signed [DOT_W:0] neg_dot;
        assign neg_dot = -((DOT_W+1)'(r_d1_dot[SQRT_STAGES-1][k]));

        tqm_angle u_angle (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_x     (neg_dot),
            .i_y     (root),
            .o_angle (ang[k])
        );
    end

    // side data alongside the angle lanes
    logic [AREA_W-1:0]  r_d2_area  [LANE_STAGES];
    logic [LROOT_W-1:0] r_d2_lmax  [LANE_STAGES];
    logic               r_d2_degen [LANE_STAGES];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2_area[0]  <= root[AREA_W:1];
            r_d2_lmax[0]  <= lroot;
            r_d2_degen[0] <= r_d1_degen[SQRT_STAGES-1];
            for (int j = 1; j < LANE_STAGES; j++) begin
                r_d2_area[j]  <= r_d2_area[j-1];
                r_d2_lmax[j]  <= r_d2_lmax[j-1];
                r_d2_degen[j] <= r_d2_degen[j-1];
            end
        end
    end

    // largest and smallest, lowest index on ties
    t_out               n_out;
    t_out               r_out;
    logic [ANGLE_W-1:0] big, small_a;
    logic [IDX_W-1:0]   bi, si;

    always_comb begin
        big     = ang[0];
        small_a = ang[0];
        bi      = '0;
        si      = '0;
        for (int k = 1; k < 3; k++) begin
            if (ang[k] > big) begin
                big = ang[k];
                bi  = IDX_W'(k);
            end
            if (ang[k] < small_a) begin
                small_a = ang[k];
                si      = IDX_W'(k);
            end
        end
        n_out.degenerate     = r_d2_degen[LANE_STAGES-1];
        n_out.area           = r_d2_area[LANE_STAGES-1];
        n_out.longest_edge   = r_d2_lmax[LANE_STAGES-1];
        n_out.largest_angle  = n_out.degenerate ? '0 : big;
        n_out.largest_index  = n_out.degenerate ? '0 : bi;
        n_out.smallest_angle = n_out.degenerate ? '0 : small_a;
        n_out.smallest_index = n_out.degenerate ? '0 : si;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

    a_degen_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |->
            o_data.largest_angle == '0 && o_data.smallest_angle == '0 &&
            o_data.largest_index == '0 && o_data.smallest_index == '0)
        else $error("degenerate item with nonzero angle fields");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.largest_angle >= o_data.smallest_angle)
        else $error("largest angle below smallest angle");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.largest_angle <= ANGLE_W'(ANGLE_MAX) &&
            o_data.largest_index != 2'd3 && o_data.smallest_index != 2'd3)
        else $error("angle or index out of range");

    a_same_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.largest_index == o_data.smallest_index |->
            o_data.largest_angle == o_data.smallest_angle)
        else $error("one vertex holds two different extremes");

endmodule
